@@ hdl/gspu_pkg.sv @@
`default_nettype none

package gspu_pkg;

  // widest code that a point can take
  localparam int MAX_CODE_BITS = 32;

  // depth of the queue between the front and the back end
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_BITS_PER_VALUE     = 3'd0;
  localparam logic [2:0] CFG_REFERENCE_VALUE    = 3'd1;
  localparam logic [2:0] CFG_BINARY_SCALE       = 3'd2;
  localparam logic [2:0] CFG_DECIMAL_MULTIPLIER = 3'd3;
  localparam logic [2:0] CFG_MISSING_VALUE      = 3'd4;
  localparam logic [2:0] CFG_LEADING_SKIP_BITS  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_DECODED  = 3'd0;
  localparam logic [2:0] ST_MISSING  = 3'd1;
  localparam logic [2:0] ST_CONSTANT = 3'd2;
  localparam logic [2:0] ST_UNDERRUN = 3'd3;
  localparam logic [2:0] ST_OVERRUN  = 3'd4;

  // reset values: multiplier 1.0 and missing value 9999.0 in q32.32
  localparam logic [62:0] DEC_MULT_RESET = 63'h0000_0001_0000_0000;
  localparam logic [63:0] MISSING_RESET  = 64'd9999 << 32;

  typedef enum logic [1:0] {
    KIND_DECODE,
    KIND_MISSING,
    KIND_CONSTANT,
    KIND_UNDERRUN
  } kind_e;

  typedef struct packed {
    logic [5:0]         bits_per_value;
    logic signed [63:0] reference_value;
    logic signed [5:0]  binary_scale;
    logic [62:0]        decimal_multiplier;
    logic signed [63:0] absent_value;
    logic [2:0]         leading_skip_bits;
  } cfg_t;

  // one classified point request
  typedef struct packed {
    kind_e                      kind;
    logic [MAX_CODE_BITS-1:0]   code;
    logic                       overrun;
  } entry_t;

endpackage

`default_nettype wire

@@ hdl/gspu_if.sv @@
`default_nettype none

interface gspu_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       present;

  modport source (output valid, operation, data_byte, present, input ready);
  modport sink   (input valid, operation, data_byte, present, output ready);
endinterface

interface gspu_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [2:0]         status;
  logic               saturated;

  modport source (output valid, value, status, saturated, input ready);
  modport sink   (input valid, value, status, saturated, output ready);
endinterface

interface gspu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/gspu_queue.sv @@
`default_nettype none

module gspu_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  gspu_pkg::entry_t     push_entry_i,
  input  wire logic            pop_i,
  output gspu_pkg::entry_t     head_o,
  output logic                 head_valid_o,
  output logic                 full_o
);
  import gspu_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PW:0]    fill_q, fill_d;
  logic           do_push, do_pop;

  assign head_valid_o = (fill_q != '0);
  assign full_o       = (fill_q == (PW+1)'(QUEUE_DEPTH));
  assign head_o       = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/gspu_front.sv @@
`default_nettype none

module gspu_front #(
  parameter int BUFFER_BITS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  gspu_in_if.sink           in_bus,
  input  gspu_pkg::cfg_t    cfg_i,
  input  wire logic         full_i,
  output logic              push_o,
  output gspu_pkg::entry_t  entry_o
);
  import gspu_pkg::*;

  localparam int CW = $clog2(BUFFER_BITS + 1);

  logic [BUFFER_BITS-1:0]   buf_q, buf_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     skip_pending_q, skip_pending_d;
  logic                     overrun_q, overrun_d;

  logic                     accept;
  logic [5:0]               width;
  logic [3:0]               nb;
  logic [7:0]               byte_m;
  logic                     fits;
  logic [CW-1:0]            k;
  logic [BUFFER_BITS-1:0]   shifted;
  logic [MAX_CODE_BITS-1:0] mask;

  assign in_bus.ready = !full_i;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    width   = (cfg_i.bits_per_value > 6'd32) ? 6'd32 : cfg_i.bits_per_value;
    nb      = skip_pending_q ? (4'd8 - {1'b0, cfg_i.leading_skip_bits}) : 4'd8;
    byte_m  = skip_pending_q ? (in_bus.data_byte & (8'hFF >> cfg_i.leading_skip_bits))
                             : in_bus.data_byte;
    fits    = ({1'b0, count_q} + (CW+1)'(nb)) <= (CW+1)'(BUFFER_BITS);
    k       = count_q - CW'(width);
    shifted = buf_q >> k;
    mask    = 32'hFFFF_FFFF >> (6'd32 - width);

    entry_o.code    = shifted[MAX_CODE_BITS-1:0] & mask;
    entry_o.overrun = overrun_q;
    if (width == 6'd0) begin
      entry_o.kind = KIND_CONSTANT;
    end else if (!in_bus.present) begin
      entry_o.kind = KIND_MISSING;
    end else if (count_q < CW'(width)) begin
      entry_o.kind = KIND_UNDERRUN;
    end else begin
      entry_o.kind = KIND_DECODE;
    end

    push_o = accept && in_bus.operation;

    buf_d          = buf_q;
    count_d        = count_q;
    skip_pending_d = skip_pending_q;
    overrun_d      = overrun_q;
    if (accept && !in_bus.operation) begin
      if (fits) begin
        buf_d          = (buf_q << nb) | BUFFER_BITS'(byte_m);
        count_d        = count_q + CW'(nb);
        skip_pending_d = 1'b0;
      end else begin
        overrun_d = 1'b1;
      end
    end else if (push_o && entry_o.kind == KIND_DECODE) begin
      count_d = k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q          <= '0;
      count_q        <= '0;
      skip_pending_q <= 1'b1;
      overrun_q      <= 1'b0;
    end else begin
      buf_q          <= buf_d;
      count_q        <= count_d;
      skip_pending_q <= skip_pending_d;
      overrun_q      <= overrun_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/gspu_back.sv @@
`default_nettype none

module gspu_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  gspu_pkg::cfg_t    cfg_i,
  input  gspu_pkg::entry_t  head_i,
  input  wire logic         head_valid_i,
  output logic              pop_o,
  gspu_out_if.source        out_bus
);
  import gspu_pkg::*;

  typedef struct packed {
    kind_e kind;
    logic  overrun;
  } tag_t;

  logic               adv;
  logic [7:1]         vld_q;
  tag_t               tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q, tag7_q;

  logic [5:0]         sh;
  logic [95:0]        a1_q;
  logic [96:0]        d2_q;
  logic [96:0]        d_neg;
  logic               neg3_q, neg4_q, neg5_q, neg6_q, neg7_q;
  logic [95:0]        m3_q;
  logic [63:0]        p00_q, p10_q, p20_q, p01_q, p11_q, p21_q;
  logic [127:0]       sum1_q, sum2_q;
  logic [159:0]       total6_q;
  logic               big7_q;
  logic [64:0]        qlr7_q;

  logic               mag_ovf;
  logic [63:0]        mag;
  logic               sat_dec;
  logic [63:0]        val_dec;

  logic               out_valid_q;
  logic signed [63:0] value_q, value_d;
  logic [2:0]         status_q, status_d;
  logic               sat_q, sat_d;

  // whole pipeline moves together, held while a result waits
  assign adv   = !out_valid_q || out_bus.ready;
  assign pop_o = adv && head_valid_i;

  // 32 + binary_scale for a 6-bit signed scale is a flip of its sign bit
  assign sh    = {~cfg_i.binary_scale[5], cfg_i.binary_scale[4:0]};
  assign d_neg = 97'd0 - d2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q <= '{kind: head_i.kind, overrun: head_i.overrun};
      a1_q   <= 96'(head_i.code) << sh;

      tag2_q <= tag1_q;
      d2_q   <= {1'b0, a1_q} + {{33{cfg_i.reference_value[63]}}, cfg_i.reference_value};

      tag3_q <= tag2_q;
      neg3_q <= d2_q[96];
      m3_q   <= d2_q[96] ? d_neg[95:0] : d2_q[95:0];

      tag4_q <= tag3_q;
      neg4_q <= neg3_q;
      p00_q  <= 64'(m3_q[31:0])  * 64'(cfg_i.decimal_multiplier[31:0]);
      p10_q  <= 64'(m3_q[63:32]) * 64'(cfg_i.decimal_multiplier[31:0]);
      p20_q  <= 64'(m3_q[95:64]) * 64'(cfg_i.decimal_multiplier[31:0]);
      p01_q  <= 64'(m3_q[31:0])  * 64'(cfg_i.decimal_multiplier[62:32]);
      p11_q  <= 64'(m3_q[63:32]) * 64'(cfg_i.decimal_multiplier[62:32]);
      p21_q  <= 64'(m3_q[95:64]) * 64'(cfg_i.decimal_multiplier[62:32]);

      // outer partial products do not overlap and are concatenated
      tag5_q <= tag4_q;
      neg5_q <= neg4_q;
      sum1_q <= {p20_q, p00_q} + {32'd0, p10_q, 32'd0};
      sum2_q <= {p21_q, p01_q} + {32'd0, p11_q, 32'd0};

      tag6_q   <= tag5_q;
      neg6_q   <= neg5_q;
      total6_q <= {32'd0, sum1_q} + {sum2_q, 32'd0};

      // q96.64 to q32.32, round half away from zero on the magnitude
      tag7_q <= tag6_q;
      neg7_q <= neg6_q;
      big7_q <= |total6_q[159:96];
      qlr7_q <= {1'b0, total6_q[95:32]} + 65'(total6_q[31]);

      value_q  <= value_d;
      status_q <= status_d;
      sat_q    <= sat_d;
    end
  end

  always_comb begin
    mag_ovf = big7_q || qlr7_q[64];
    mag     = qlr7_q[63:0];
    if (neg7_q) begin
      sat_dec = mag_ovf || (mag > 64'h8000_0000_0000_0000);
      val_dec = sat_dec ? 64'h8000_0000_0000_0000 : (64'd0 - mag);
    end else begin
      sat_dec = mag_ovf || mag[63];
      val_dec = sat_dec ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
    end

    unique case (tag7_q.kind)
      KIND_DECODE: begin
        value_d  = val_dec;
        status_d = tag7_q.overrun ? ST_OVERRUN : ST_DECODED;
        sat_d    = sat_dec;
      end
      KIND_MISSING: begin
        value_d  = cfg_i.absent_value;
        status_d = ST_MISSING;
        sat_d    = 1'b0;
      end
      KIND_CONSTANT: begin
        value_d  = cfg_i.reference_value;
        status_d = ST_CONSTANT;
        sat_d    = 1'b0;
      end
      KIND_UNDERRUN: begin
        value_d  = '0;
        status_d = ST_UNDERRUN;
        sat_d    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[6:1], head_valid_i};
      out_valid_q <= vld_q[7];
    end
  end

  assign out_bus.valid     = out_valid_q;
  assign out_bus.value     = value_q;
  assign out_bus.status    = status_q;
  assign out_bus.saturated = sat_q;

endmodule

`default_nettype wire

@@ hdl/grib_simple_packing_unpacker_top.sv @@
// simple-packed point decoder
//
// in_bus beats carry either a packed data byte (operation 0), appended msb
// first to a bit buffer of BUFFER_BITS bits, or a point request (operation 1)
// with its bitmap bit in present. a byte beat gives no result; every request
// gives exactly one out_bus beat with value, status and saturated.
// cfg_bus writes the six decoder registers by index, one beat per cycle, and
// must only be used while no request is in flight.
//
// throughput: one in_bus beat per cycle, bytes and requests alike, while
// in_bus ready is high; the bit buffer update and code extraction finish in
// the cycle a beat is taken. a request passes the queue, then the
// 7 arithmetic stages (shift, reference add, magnitude, 32x32 partial
// products, two partial-product adds, rounding) and the output register.
// a 4-entry queue sits between the front end and the arithmetic pipeline.
// when out_bus stalls the pipeline holds, the queue fills and in_bus ready
// falls once it is full; nothing is dropped.
// reset: buffer empty, leading-bit skip armed for the first byte, overrun
// flag clear, registers at defaults (multiplier 1.0, missing value 9999.0)
`default_nettype none

module grib_simple_packing_unpacker_top #(
  parameter int BUFFER_BITS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gspu_in_if.sink    in_bus,
  gspu_out_if.source out_bus,
  gspu_cfg_if.sink   cfg_bus
);
  import gspu_pkg::*;

  cfg_t   cfg_q;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_head_valid;
  entry_t front_entry;
  entry_t q_head;

  // register writes are always taken
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits_per_value     <= '0;
      cfg_q.reference_value    <= '0;
      cfg_q.binary_scale       <= '0;
      cfg_q.decimal_multiplier <= DEC_MULT_RESET;
      cfg_q.absent_value       <= MISSING_RESET;
      cfg_q.leading_skip_bits  <= '0;
    end else if (cfg_bus.valid) begin
      // indexes past the last register are ignored
      unique case (cfg_bus.index)
        CFG_BITS_PER_VALUE:     cfg_q.bits_per_value     <= cfg_bus.data[5:0];
        CFG_REFERENCE_VALUE:    cfg_q.reference_value    <= cfg_bus.data;
        CFG_BINARY_SCALE:       cfg_q.binary_scale       <= cfg_bus.data[5:0];
        CFG_DECIMAL_MULTIPLIER: cfg_q.decimal_multiplier <= cfg_bus.data[62:0];
        CFG_MISSING_VALUE:      cfg_q.absent_value       <= cfg_bus.data;
        CFG_LEADING_SKIP_BITS:  cfg_q.leading_skip_bits  <= cfg_bus.data[2:0];
        default: begin
        end
      endcase
    end
  end

  // front end: bit buffer, skip, overrun and request classification
  gspu_front #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_bus  (in_bus),
    .cfg_i   (cfg_q),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (front_entry)
  );

  // classified requests wait here for the arithmetic pipeline
  gspu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (front_entry),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .head_valid_o (q_head_valid),
    .full_o       (q_full)
  );

  // back end: scaling, rounding, saturation and the output register
  gspu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (q_head),
    .head_valid_i (q_head_valid),
    .pop_o        (q_pop),
    .out_bus      (out_bus)
  );

endmodule

`default_nettype wire

@@ hdl/gspu_checker.sv @@
`default_nettype none

module gspu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] out_value_i,
  input wire logic [2:0]  out_status_i,
  input wire logic        out_saturated_i
);
  import gspu_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i)
      && $stable(out_status_i) && $stable(out_saturated_i))
    else $error("stalled result beat changed");

  // clipping only on decoded points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_saturated_i |->
      out_status_i == ST_DECODED || out_status_i == ST_OVERRUN)
    else $error("saturated set on a point that was not decoded");

  // underrun gives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_UNDERRUN |-> out_value_i == 64'd0)
    else $error("underrun result is not zero");

  // clipped values sit at one of the two limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_saturated_i |->
      out_value_i == 64'h7FFF_FFFF_FFFF_FFFF || out_value_i == 64'h8000_0000_0000_0000)
    else $error("saturated value is not a range limit");

endmodule

bind grib_simple_packing_unpacker_top gspu_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_bus.valid),
  .out_ready_i     (out_bus.ready),
  .out_value_i     (out_bus.value),
  .out_status_i    (out_bus.status),
  .out_saturated_i (out_bus.saturated)
);

`default_nettype wire

@@ tb/gspu_point_check.sv @@
`timescale 1ns / 100ps

module gspu_point_check #(
  parameter int BUFFER_BITS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gspu_in_if         in_mon,
  gspu_out_if        out_mon,
  gspu_cfg_if        cfg_mon,
  output int         fail_count_o,
  output int         pending_o,
  output int         result_count_o,
  output int         sat_count_o,
  output logic [4:0] status_seen_o
);
  import gspu_pkg::*;

  localparam logic OP_PUSH = 1'b0;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
    logic               saturated;
  } point_t;

  cfg_t         regs;
  logic [127:0] bit_store;
  int           bit_fill;
  logic         skip_armed;
  logic         overrun_seen;
  point_t       points_due[$];
  int           fails;
  int           results;
  int           sats;
  logic [4:0]   seen;

  // (code * 2^scale + reference) * multiplier, round half away from zero, clip to 64 bits
  function automatic point_t scale_code(input cfg_t c, input logic [31:0] code);
    logic [7:0]   shift_sum;
    logic [127:0] shifted;
    logic [129:0] sum;
    logic [129:0] mag;
    logic [193:0] prod;
    logic [161:0] rounded;
    logic         neg;
    point_t       r;
    shift_sum = 8'd32 + {{2{c.binary_scale[5]}}, c.binary_scale};
    shifted   = {96'd0, code} << shift_sum[6:0];
    sum       = {2'b00, shifted} + {{66{c.reference_value[63]}}, c.reference_value};
    neg       = sum[129];
    mag       = neg ? (~sum + 130'd1) : sum;
    prod      = {64'd0, mag} * {131'd0, c.decimal_multiplier};
    rounded   = prod[193:32] + {161'd0, prod[31]};
    r.status    = ST_DECODED;
    r.saturated = 1'b0;
    if (neg) begin
      if (rounded > {98'd0, 64'h8000_0000_0000_0000}) begin
        r.saturated = 1'b1;
        r.value     = 64'h8000_0000_0000_0000;
      end else begin
        r.value = ~rounded[63:0] + 64'd1;
      end
    end else if (rounded > {98'd0, 64'h7FFF_FFFF_FFFF_FFFF}) begin
      r.saturated = 1'b1;
      r.value     = 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r.value = rounded[63:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    point_t      want;
    point_t      got;
    logic [2:0]  drop;
    logic [7:0]  byte_bits;
    int          nb;
    int          width;
    logic [31:0] code;
    if (!rst_ni) begin
      regs.bits_per_value     = '0;
      regs.reference_value    = '0;
      regs.binary_scale       = '0;
      regs.decimal_multiplier = DEC_MULT_RESET;
      regs.absent_value       = MISSING_RESET;
      regs.leading_skip_bits  = '0;
      bit_store    = '0;
      bit_fill     = 0;
      skip_armed   = 1'b1;
      overrun_seen = 1'b0;
      points_due.delete();
      fails   = 0;
      results = 0;
      sats    = 0;
      seen    = '0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BITS_PER_VALUE:     regs.bits_per_value     = cfg_mon.data[5:0];
          CFG_REFERENCE_VALUE:    regs.reference_value    = cfg_mon.data;
          CFG_BINARY_SCALE:       regs.binary_scale       = cfg_mon.data[5:0];
          CFG_DECIMAL_MULTIPLIER: regs.decimal_multiplier = cfg_mon.data[62:0];
          CFG_MISSING_VALUE:      regs.absent_value       = cfg_mon.data;
          CFG_LEADING_SKIP_BITS:  regs.leading_skip_bits  = cfg_mon.data[2:0];
          default: ;
        endcase
      end

      // compare before predicting so a stray beat never meets a same-cycle request
      if (out_mon.valid && out_mon.ready) begin
        got.value     = out_mon.value;
        got.status    = out_mon.status;
        got.saturated = out_mon.saturated;
        results++;
        if (points_due.size() == 0) begin
          fails++;
          $display("%0t ns: result beat with nothing expected: value %h status %0d sat %b",
                   $time, got.value, got.status, got.saturated);
        end else begin
          want = points_due.pop_front();
          if (want.saturated) sats++;
          seen[want.status] = 1'b1;
          if (got !== want) begin
            fails++;
            $display("%0t ns: expected value %h status %0d sat %b, got value %h status %0d sat %b",
                     $time, want.value, want.status, want.saturated,
                     got.value, got.status, got.saturated);
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_PUSH) begin
          drop      = skip_armed ? regs.leading_skip_bits : 3'd0;
          nb        = 8 - int'(drop);
          byte_bits = in_mon.data_byte & (8'hFF >> drop);
          if (bit_fill + nb > BUFFER_BITS) begin
            overrun_seen = 1'b1;
          end else begin
            bit_store  = (bit_store << nb) | {120'd0, byte_bits};
            bit_fill   = bit_fill + nb;
            skip_armed = 1'b0;
          end
        end else begin
          width = (regs.bits_per_value > 6'd32) ? 32 : int'(regs.bits_per_value);
          want.saturated = 1'b0;
          if (width == 0) begin
            want.value  = regs.reference_value;
            want.status = ST_CONSTANT;
          end else if (!in_mon.present) begin
            want.value  = regs.absent_value;
            want.status = ST_MISSING;
          end else if (bit_fill < width) begin
            want.value  = '0;
            want.status = ST_UNDERRUN;
          end else begin
            code     = 32'((bit_store >> (bit_fill - width)) & ((128'd1 << width) - 128'd1));
            bit_fill = bit_fill - width;
            want     = scale_code(regs, code);
            want.status = overrun_seen ? ST_OVERRUN : ST_DECODED;
          end
          points_due.insert(points_due.size(), want);
        end
      end
    end
    fail_count_o   <= fails;
    pending_o      <= points_due.size();
    result_count_o <= results;
    sat_count_o    <= sats;
    status_seen_o  <= seen;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import gspu_pkg::*;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam int BUF_BITS    = 64;
  localparam int SETTLE      = 16;    // settle time once the last expected result is in
  localparam int STALL_LIMIT = 2000;  // idle cycles before the watchdog fires
  localparam int HOLD_CYCLES = 300;   // long result back-pressure stretch
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int TAIL_ITEMS  = 150;

  logic clk;
  logic rst_n;

  gspu_in_if  in_bus ();
  gspu_out_if out_bus ();
  gspu_cfg_if cfg_bus ();

  int         fail_count;
  int         pending;
  int         result_count;
  int         sat_count;
  logic [4:0] status_seen;

  // rough picture of the bit buffer, only used to steer stimulus
  int   bits_held;
  int   width_now;
  int   skip_now;
  logic first_byte;

  logic calm;      // no idling on either side while set
  logic squeeze;   // asks the result side for one long hold-off
  int   byte_beats;
  int   point_beats;
  int   settings_used;
  int   idle_cycles;

  grib_simple_packing_unpacker_top #(
    .BUFFER_BITS(BUF_BITS)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  gspu_point_check #(
    .BUFFER_BITS(BUF_BITS)
  ) point_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_mon       (cfg_bus),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .result_count_o(result_count),
    .sat_count_o   (sat_count),
    .status_seen_o (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one input beat: random idle cycles first unless calm, then hold until taken
  task automatic send_beat(input logic op, input logic [7:0] data, input logic pres);
    if (!calm) begin
      while ($urandom_range(0, 99) < 27) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.data_byte <= data;
    in_bus.present   <= pres;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic push_byte(input logic [7:0] data);
    int nb;
    nb = first_byte ? 8 - skip_now : 8;
    // present is a don't-care on a byte beat, toggle it anyway
    send_beat(OP_PUSH, data, 1'($urandom_range(0, 1)));
    byte_beats++;
    if (bits_held + nb <= BUF_BITS) begin
      bits_held += nb;
      first_byte = 1'b0;
    end
  endtask

  task automatic ask_point(input logic pres);
    send_beat(OP_POINT, 8'($urandom), pres);
    point_beats++;
    if (width_now != 0 && pres && bits_held >= width_now) bits_held -= width_now;
  endtask

  // stop offering, wait for every expected result, then let the pipe settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one config beat; valid stays high so back-to-back writes do not toggle it
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_BITS_PER_VALUE) width_now = (data[5:0] > 6'd32) ? 32 : int'(data[5:0]);
    if (idx == CFG_LEADING_SKIP_BITS) skip_now = int'(data[2:0]);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_BITS_PER_VALUE, {58'd0, c.bits_per_value});
    write_reg(CFG_REFERENCE_VALUE, c.reference_value);
    write_reg(CFG_BINARY_SCALE, {{58{c.binary_scale[5]}}, c.binary_scale});
    write_reg(CFG_DECIMAL_MULTIPLIER, {1'b0, c.decimal_multiplier});
    write_reg(CFG_MISSING_VALUE, c.absent_value);
    write_reg(CFG_LEADING_SKIP_BITS, {61'd0, c.leading_skip_bits});
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // half of the settings keep values in range so plain decodes show up,
  // the rest are wide open and mostly saturate
  function automatic cfg_t pick_settings();
    cfg_t c;
    int   roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) c.bits_per_value = 6'd0;
    else if (roll < 7) c.bits_per_value = 6'($urandom_range(1, 16));
    else if (roll < 9) c.bits_per_value = 6'($urandom_range(17, 32));
    else c.bits_per_value = 6'($urandom_range(33, 63));
    if ($urandom_range(0, 1)) begin
      c.reference_value = $signed({$urandom, $urandom}) >>> $urandom_range(16, 40);
      c.binary_scale    = 6'($urandom_range(0, 16) - 8);
      case ($urandom_range(0, 3))
        0: c.decimal_multiplier = 63'h1_0000_0000;      // 1.0
        1: c.decimal_multiplier = 63'd429496730;        // about 0.1
        2: c.decimal_multiplier = 63'd42949672960;      // 10.0
        default: c.decimal_multiplier = 63'($urandom) << $urandom_range(0, 2);
      endcase
    end else begin
      c.reference_value    = {$urandom, $urandom};
      c.binary_scale       = 6'($urandom);
      c.decimal_multiplier = 63'({$urandom, $urandom}) >> $urandom_range(0, 40);
      if ($urandom_range(0, 7) == 0) c.decimal_multiplier = '1;
    end
    c.absent_value      = {$urandom, $urandom};
    c.leading_skip_bits = 3'($urandom);
    return c;
  endfunction

  // mostly well-formed traffic: bytes in, codes out, buffer never overflowing;
  // a few stray requests land on a short buffer. with overflow_ok the buffer
  // is pushed past its end and the sticky overrun shows on later decodes
  task automatic run_stream(input int count, input logic overflow_ok);
    int k;
    int roll;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (overflow_ok) begin
        if (roll < 55) push_byte(8'($urandom));
        else ask_point(roll < 90);
      end else if (roll < 5) begin
        ask_point(1'($urandom_range(0, 1)));
      end else if (width_now != 0 && bits_held >= width_now &&
                   (bits_held + 8 > BUF_BITS || roll < 55)) begin
        ask_point($urandom_range(0, 99) < 85);
      end else if (bits_held + 8 <= BUF_BITS) begin
        push_byte(8'($urandom));
      end else begin
        ask_point(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // result side: random ready, steady ready while calm, one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (calm) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // watchdog: any channel moving a beat resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: watchdog, no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    cfg_t set;
    int   ph;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_PUSH;
    in_bus.data_byte <= '0;
    in_bus.present   <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= CFG_BITS_PER_VALUE;
    cfg_bus.data     <= '0;
    bits_held     = 0;
    width_now     = 0;
    skip_now      = 0;
    first_byte    = 1'b1;
    calm          = 1'b0;
    squeeze       = 1'b0;
    byte_beats    = 0;
    point_beats   = 0;
    settings_used = 0;
    idle_cycles   = 0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults give a constant field, present bit ignored
    ask_point(1'b1);
    ask_point(1'b0);
    drain();

    // 8-bit codes, first byte loses seven of its bits
    write_reg(CFG_BITS_PER_VALUE, 64'd8);
    write_reg(CFG_LEADING_SKIP_BITS, 64'd7);
    cfg_bus.valid <= 1'b0;
    ask_point(1'b0);           // absent point, default missing value
    ask_point(1'b1);           // empty buffer, underrun
    push_byte(8'hFF);          // only one bit survives the skip
    push_byte(8'h00);
    push_byte(8'hAB);
    ask_point(1'b1);
    ask_point(1'b1);
    ask_point(1'b1);           // one bit left, underrun again
    drain();

    // widest code via an oversized width, everything at the top: saturates high
    set = '{bits_per_value: 6'd63, reference_value: 64'h7FFF_FFFF_FFFF_FFFF,
            binary_scale: 6'b011111, decimal_multiplier: 63'h7FFF_FFFF_FFFF_FFFF,
            absent_value: 64'h8000_0000_0000_0000, leading_skip_bits: 3'd0};
    apply_settings(set);
    push_byte(8'h80);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h01);
    ask_point(1'b1);
    ask_point(1'b0);           // most negative missing value
    drain();

    // most negative reference, smallest scale, unity multiplier
    set = '{bits_per_value: 6'd32, reference_value: 64'h8000_0000_0000_0000,
            binary_scale: 6'b100000, decimal_multiplier: 63'h1_0000_0000,
            absent_value: 64'd0, leading_skip_bits: 3'd7};
    apply_settings(set);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFF);
    ask_point(1'b1);
    drain();

    // multiplier one half puts odd sums of code and reference exactly on a rounding tie
    set = '{bits_per_value: 6'd4, reference_value: -64'sd5,
            binary_scale: 6'b100000, decimal_multiplier: 63'h8000_0000,
            absent_value: 64'h7FFF_FFFF_FFFF_FFFF, leading_skip_bits: 3'd3};
    apply_settings(set);
    push_byte(8'h3C);
    ask_point(1'b1);
    ask_point(1'b1);
    drain();

    // random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      set = pick_settings();
      if (ph == 0) begin
        set.bits_per_value     = 6'd1;
        set.decimal_multiplier = '0;
      end
      if (ph == 1) set.bits_per_value = 6'd32;
      apply_settings(set);
      calm = (ph == 3);
      // hold the result side off while bytes and requests keep coming
      if (ph == 5) squeeze = 1'b1;
      run_stream(PHASE_ITEMS, 1'b0);
      calm = 1'b0;
      drain();
    end

    // last stretch overflows the buffer; overrun stays set until the end
    apply_settings(pick_settings());
    run_stream(TAIL_ITEMS, 1'b1);
    drain();

    $display("covered %0d byte beats and %0d point requests over %0d register settings",
             byte_beats, point_beats, settings_used);
    $display("checked %0d results, %0d saturated, status codes seen %b",
             result_count, sat_count, status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ grib_simple_packing_unpacker_top.f @@
hdl/gspu_pkg.sv
hdl/gspu_if.sv
hdl/gspu_queue.sv
hdl/gspu_front.sv
hdl/gspu_back.sv
hdl/grib_simple_packing_unpacker_top.sv
hdl/gspu_checker.sv
tb/gspu_point_check.sv
tb/tb.sv
